### rtl/cle_pkg.sv
// shared constants, types and character tables of the console line editor
package cle_pkg;

   localparam int LINE_CAPACITY = 1024;
   localparam int ADDR_W        = $clog2(LINE_CAPACITY);
   localparam int LEN_W         = 10;
   localparam int LEN_MAX       = (1 << LEN_W) - 1;
   localparam int WORD_LEN      = 11;
   localparam int SCAN_MAX      = WORD_LEN + 1;
   localparam int SCAN_W        = $clog2(SCAN_MAX + 1);

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_STAR  = 8'h2A;

   typedef enum logic [1:0] {
      EV_ECHO = 2'd0,
      EV_LINE = 2'd1,
      EV_OVER = 2'd2
   } event_kind_type;

   // one result word handed from the sequencer to the output stage
   typedef struct packed {
      logic                 valid;
      event_kind_type       kind;
      logic [7:0]           echo_byte;
      logic [LEN_W-1:0]     line_length;
      logic                 last;
   } evt_type;

   // first masked command word
   function automatic logic [7:0] mask_char_a(input logic [SCAN_W-1:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = "s";
         4'd1:    ch = "e";
         4'd2:    ch = "t";
         4'd3:    ch = "_";
         4'd4:    ch = "w";
         4'd5:    ch = "i";
         4'd6:    ch = "f";
         4'd7:    ch = "i";
         4'd8:    ch = "p";
         4'd9:    ch = "w";
         4'd10:   ch = "d";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // second masked command word
   function automatic logic [7:0] mask_char_b(input logic [SCAN_W-1:0] idx);
      logic [7:0] ch;
      case (idx)
         4'd0:    ch = "s";
         4'd1:    ch = "e";
         4'd2:    ch = "t";
         4'd3:    ch = "_";
         4'd4:    ch = "d";
         4'd5:    ch = "p";
         4'd6:    ch = "s";
         4'd7:    ch = "_";
         4'd8:    ch = "u";
         4'd9:    ch = "d";
         4'd10:   ch = "s";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // line length reported on carriage return, saturated to the field width
   function automatic logic [LEN_W-1:0] len_sat(input logic [ADDR_W-1:0] pos);
      logic [LEN_W-1:0] len;
      if (int'(pos) > LEN_MAX) begin
         len = LEN_W'(LEN_MAX);
      end else begin
         len = LEN_W'(pos);
      end
      return len;
   endfunction

endpackage

### rtl/cle_if.sv
// valid/ready channel interfaces for received bytes and editor results
interface cle_req_if import cle_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cle_rsp_if import cle_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       event_kind;
   logic [7:0]       echo_byte;
   logic [LEN_W-1:0] line_length;
   logic             last_of_run;

   modport source (output valid, output event_kind, output echo_byte,
                   output line_length, output last_of_run, input ready);
   modport sink (input valid, input event_kind, input echo_byte,
                 input line_length, input last_of_run, output ready);
endinterface

### rtl/cle_line_ram.sv
// line buffer memory, one write and one registered read port
module cle_line_ram import cle_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [LINE_CAPACITY];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cle_seq.sv
// byte decoder, first-word scan over the line buffer and result sequencing
module cle_seq import cle_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   cle_req_if.sink           req_chan,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data,
   output evt_type           evt,
   input  logic              evt_ready
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_STORE = 4'b0100,
      ST_EMIT  = 4'b1000
   } seq_state_type;

   typedef enum logic [1:0] {
      PLAN_LINE  = 2'd0,
      PLAN_ERASE = 2'd1,
      PLAN_ECHO  = 2'd2
   } plan_type;

   seq_state_type     state_ff, state_in;
   plan_type          plan_ff, plan_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [1:0]        step_ff, step_in;
   logic [1:0]        last_ff, last_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [7:0]        stored_ff, stored_in;
   logic [7:0]        echo_ff, echo_in;
   logic [SCAN_W-1:0] scan_idx_ff, scan_idx_in;
   logic [SCAN_W-1:0] lim_ff, lim_in;
   logic [SCAN_W-1:0] chk_idx_ff, chk_idx_in;
   logic              chk_vld_ff, chk_vld_in;
   logic              ma_ff, ma_in;
   logic              mb_ff, mb_in;
   logic              mask_ff, mask_in;
   logic              issue;
   logic [7:0]        rx;

   assign rx      = req_chan.rx_byte;
   assign issue   = (state_ff == ST_SCAN) && (scan_idx_ff != lim_ff);
   assign rd_en   = issue;
   assign rd_addr = ADDR_W'(scan_idx_ff);
   assign wr_en   = (state_ff == ST_STORE);
   assign wr_addr = pos_ff;
   assign wr_data = stored_ff;

   always_comb begin
      state_in    = state_ff;
      plan_in     = plan_ff;
      pos_in      = pos_ff;
      step_in     = step_ff;
      last_in     = last_ff;
      len_in      = len_ff;
      stored_in   = stored_ff;
      echo_in     = echo_ff;
      scan_idx_in = scan_idx_ff;
      lim_in      = lim_ff;
      chk_idx_in  = chk_idx_ff;
      chk_vld_in  = 1'b0;
      ma_in       = ma_ff;
      mb_in       = mb_ff;
      mask_in     = mask_ff;
      req_chan.ready  = 1'b0;
      evt             = '0;
      evt.kind        = EV_ECHO;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               if (rx == CH_CR) begin
                  len_in   = len_sat(pos_ff);
                  pos_in   = '0;
                  plan_in  = PLAN_LINE;
                  step_in  = 2'd0;
                  last_in  = 2'd0;
                  state_in = ST_EMIT;
               end else if (rx == CH_BS || rx == CH_DEL) begin
                  if (pos_ff != '0) begin
                     pos_in   = pos_ff - 1'b1;
                     plan_in  = PLAN_ERASE;
                     step_in  = 2'd0;
                     last_in  = 2'd2;
                     state_in = ST_EMIT;
                  end
               end else if (rx == CH_TAB || rx >= CH_SPACE) begin
                  stored_in   = (rx == CH_TAB) ? CH_SPACE : rx;
                  mask_in     = 1'b0;
                  ma_in       = 1'b1;
                  mb_in       = 1'b1;
                  scan_idx_in = '0;
                  if (int'(pos_ff) < SCAN_MAX) begin
                     lim_in = SCAN_W'(pos_ff);
                  end else begin
                     lim_in = SCAN_W'(SCAN_MAX);
                  end
                  // an empty prefix cannot hold the command word
                  state_in = (pos_ff == '0) ? ST_STORE : ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (issue) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            chk_vld_in = issue;
            chk_idx_in = scan_idx_ff;
            if (chk_vld_ff) begin
               if (rd_data == CH_SPACE) begin
                  mask_in  = (chk_idx_ff == SCAN_W'(WORD_LEN)) && (ma_ff || mb_ff);
                  state_in = ST_STORE;
               end else if (chk_idx_ff == SCAN_W'(WORD_LEN)) begin
                  // first word longer than the command words
                  state_in = ST_STORE;
               end else begin
                  ma_in = ma_ff && (rd_data == mask_char_a(chk_idx_ff));
                  mb_in = mb_ff && (rd_data == mask_char_b(chk_idx_ff));
                  if (chk_idx_ff == lim_ff - 1'b1) begin
                     state_in = ST_STORE;
                  end
               end
            end
         end

         ST_STORE: begin
            echo_in  = mask_ff ? CH_STAR : stored_ff;
            plan_in  = PLAN_ECHO;
            step_in  = 2'd0;
            state_in = ST_EMIT;
            if (pos_ff == ADDR_W'(LINE_CAPACITY - 1)) begin
               pos_in  = '0;
               last_in = 2'd1;
            end else begin
               pos_in  = pos_ff + 1'b1;
               last_in = 2'd0;
            end
         end

         ST_EMIT: begin
            evt.valid = 1'b1;
            evt.last  = (step_ff == last_ff);
            case (plan_ff)
               PLAN_LINE: begin
                  evt.kind        = EV_LINE;
                  evt.line_length = len_ff;
               end
               PLAN_ERASE: begin
                  evt.echo_byte = (step_ff == 2'd1) ? CH_SPACE : CH_BS;
               end
               PLAN_ECHO: begin
                  if (step_ff == 2'd0) begin
                     evt.echo_byte = echo_ff;
                  end else begin
                     evt.kind = EV_OVER;
                  end
               end
               default: begin
                  evt.valid = 1'b0;
               end
            endcase
            if (evt_ready) begin
               step_in = step_ff + 1'b1;
               if (step_ff == last_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff     <= plan_in;
      step_ff     <= step_in;
      last_ff     <= last_in;
      len_ff      <= len_in;
      stored_ff   <= stored_in;
      echo_ff     <= echo_in;
      scan_idx_ff <= scan_idx_in;
      lim_ff      <= lim_in;
      chk_idx_ff  <= chk_idx_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      mask_ff     <= mask_in;
   end

endmodule

### rtl/cle_rsp_stage.sv
// output register between the sequencer and the result channel
module cle_rsp_stage import cle_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  evt_type  evt,
   output logic     evt_ready,
   cle_rsp_if.source rsp_chan
);

   evt_type hold_ff, hold_in;
   logic    valid_ff, valid_in;

   assign evt_ready = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      hold_in  = hold_ff;
      if (evt_ready) begin
         valid_in = evt.valid;
         hold_in  = evt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.event_kind  = hold_ff.kind;
   assign rsp_chan.echo_byte   = hold_ff.echo_byte;
   assign rsp_chan.line_length = hold_ff.line_length;
   assign rsp_chan.last_of_run = hold_ff.last;

endmodule

### rtl/console_line_editor_echo.sv
// top level of the serial console line editor with echo
// Console line editor: each byte taken on req_chan edits a 1024-byte line
// buffer held in a single-port-write, registered-read memory, and the echo
// and line events leave on rsp_chan, with last_of_run marking the final word
// caused by one received byte. A carriage return gives a line-ready word with
// the length and empties the line; tab is stored as a space; backspace or
// delete on a non-empty line gives backspace, space, backspace; other control
// bytes give nothing. A printable byte (0x20 and up, 0x80..0xff included) is
// stored and echoed, or echoed as '*' while the line so far starts with one
// of the two masked command words followed by a space; the store that fills
// the buffer is followed by an overflow word and the line is dropped.
// One byte at a time: the next byte is taken only after every result word of
// the last one has entered the output register, so a stall on rsp_chan holds
// the input. A printable byte on a non-empty line first has the first-word
// check walk the buffer through its one read port, examining at most 12
// prefix entries. The last result may wait in the output register while
// the next byte is already taken. No clearing pass: the buffer is only read
// below the write position, which the current line has written.
module console_line_editor_echo import cle_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cle_req_if.sink   req_chan,
   cle_rsp_if.source rsp_chan
);

   // memory ports
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   // result word from the sequencer into the output register
   evt_type           evt;
   logic              evt_ready;

   // line buffer; the scan reads and the store write never touch the same
   // entry in overlapping cycles, since the store follows the finished scan
   cle_line_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // decode, write position, masked-word scan and result sequencing
   cle_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .evt       (evt),
      .evt_ready (evt_ready)
   );

   // output register driving the result channel
   cle_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .evt       (evt),
      .evt_ready (evt_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule

### rtl/cle_checker.sv
// port-level checks of the console line editor and their bind
module cle_checker import cle_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [1:0]       rsp_event_kind,
   input logic [7:0]       rsp_echo_byte,
   input logic [LEN_W-1:0] rsp_line_length,
   input logic             rsp_last_of_run
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_echo_byte) && $stable(rsp_line_length)
         && $stable(rsp_last_of_run))
      else $error("result word changed while stalled");

   // line ready and overflow always close the run of one byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_LINE || rsp_event_kind == EV_OVER)
         |-> rsp_last_of_run)
      else $error("line or overflow word not last of run");

   // unused fields are zero
   a_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_kind == EV_ECHO || rsp_echo_byte == 8'h00)
         && (rsp_event_kind == EV_LINE || rsp_line_length == '0))
      else $error("field set outside its event kind");

   // the overflow word directly follows its echo word
   a_over_after_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_OVER && rsp_last_of_run
         |-> $past(rsp_event_kind) == EV_ECHO || $past(rsp_valid && !rsp_ready))
      else $error("overflow word without preceding echo");

   // event kind three never appears
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_kind == EV_ECHO || rsp_event_kind == EV_LINE
         || rsp_event_kind == EV_OVER)
      else $error("undefined event kind");

endmodule

bind console_line_editor_echo cle_checker u_cle_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_event_kind  (rsp_chan.event_kind),
   .rsp_echo_byte   (rsp_chan.echo_byte),
   .rsp_line_length (rsp_chan.line_length),
   .rsp_last_of_run (rsp_chan.last_of_run)
);

### test/cle_tb_pkg.sv
// line editor predictor and echo word scoreboard for the console line editor bench
package cle_tb_pkg;
   import cle_pkg::*;

   typedef struct packed {
      event_kind_type   kind;
      logic [7:0]       echo_byte;
      logic [LEN_W-1:0] line_length;
      logic             last;
   } echo_word_type;

   class line_echo_scoreboard;
      logic [7:0]    line_buf [LINE_CAPACITY];
      int unsigned   cursor;
      echo_word_type expected_words [$];
      logic [7:0]    masked_cmd [2][WORD_LEN];
      int unsigned   error_count;
      int unsigned   words_checked;
      int unsigned   lines_done;
      int unsigned   overflows;
      int unsigned   masked_echoes;
      int unsigned   erases;

      function new();
         int unsigned k;
         cursor = 0;
         for (k = 0; k < WORD_LEN; k++) begin
            masked_cmd[0][k] = mask_char_a(SCAN_W'(k));
            masked_cmd[1][k] = mask_char_b(SCAN_W'(k));
         end
      endfunction

      // first word of the line so far is a masked command followed by a space
      function bit prefix_hidden();
         int unsigned j;
         int unsigned w;
         int unsigned k;
         bit          same;
         for (j = 0; j < cursor; j++) begin
            if (line_buf[j] == CH_SPACE) begin
               if (j != WORD_LEN) return 1'b0;
               for (w = 0; w < 2; w++) begin
                  same = 1'b1;
                  for (k = 0; k < WORD_LEN; k++) begin
                     if (line_buf[k] != masked_cmd[w][k]) same = 1'b0;
                  end
                  if (same) return 1'b1;
               end
               return 1'b0;
            end
         end
         return 1'b0;
      endfunction

      function void push_word(input event_kind_type kind, input logic [7:0] ch,
                              input logic [LEN_W-1:0] len);
         echo_word_type w;
         w.kind        = kind;
         w.echo_byte   = ch;
         w.line_length = len;
         w.last        = 1'b0;
         expected_words.push_back(w);
      endfunction

      // accepted received byte: update the line and queue the words it causes
      function void note_byte(input logic [7:0] b);
         int unsigned      queued;
         logic [7:0]       stored;
         logic [LEN_W-1:0] len;
         bit               hide;
         queued = expected_words.size();
         if (cursor >= LINE_CAPACITY) cursor = 0;
         if (b == CH_CR) begin
            len = (cursor > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(cursor);
            push_word(EV_LINE, 8'h00, len);
            cursor = 0;
            lines_done++;
         end else if (b == CH_BS || b == CH_DEL) begin
            if (cursor > 0) begin
               cursor--;
               push_word(EV_ECHO, CH_BS, '0);
               push_word(EV_ECHO, CH_SPACE, '0);
               push_word(EV_ECHO, CH_BS, '0);
               erases++;
            end
         end else if (b == CH_TAB || b >= CH_SPACE) begin
            stored = (b == CH_TAB) ? CH_SPACE : b;
            hide   = prefix_hidden();
            line_buf[cursor] = stored;
            push_word(EV_ECHO, hide ? CH_STAR : stored, '0);
            if (hide) masked_echoes++;
            cursor++;
            if (cursor >= LINE_CAPACITY) begin
               push_word(EV_OVER, 8'h00, '0);
               cursor = 0;
               overflows++;
            end
         end
         if (expected_words.size() > queued) begin
            expected_words[expected_words.size() - 1].last = 1'b1;
         end
      endfunction

      function void report(input realtime stamp, input string field,
                           input int unsigned want, input int unsigned got);
         error_count++;
         if (error_count <= 30) begin
            $display("%0.1f ns: %s mismatch, expected 'h%0h, actual 'h%0h",
                     stamp, field, want, got);
         end
      endfunction

      // compare one word taken from the block with the oldest expected word
      function void check_word(input echo_word_type got, input realtime stamp);
         echo_word_type want;
         if (expected_words.size() == 0) begin
            error_count++;
            if (error_count <= 30) begin
               $display("%0.1f ns: unexpected word, expected none, actual kind %0d byte 'h%0h",
                        stamp, got.kind, got.echo_byte);
            end
            return;
         end
         want = expected_words.pop_front();
         words_checked++;
         if (got.kind !== want.kind) report(stamp, "event_kind", want.kind, got.kind);
         if (got.echo_byte !== want.echo_byte) begin
            report(stamp, "echo_byte", want.echo_byte, got.echo_byte);
         end
         if (got.line_length !== want.line_length) begin
            report(stamp, "line_length", want.line_length, got.line_length);
         end
         if (got.last !== want.last) report(stamp, "last_of_run", want.last, got.last);
      endfunction
   endclass

endpackage

### test/console_line_editor_echo_tb.sv
// top level bench of the console line editor: stimulus, flow control and checking
module console_line_editor_echo_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cle_pkg::*;
   import cle_tb_pkg::*;

   // cycles without any accepted word before the run is declared hung
   localparam int unsigned STALL_LIMIT = 3000;
   // length of the deliberate receiver hold-off
   localparam int unsigned HOLD_CYCLES = 300;
   // quiet cycles after the last expected word, ignored bytes may still be in flight
   localparam int unsigned DRAIN_CYCLES = 40;

   logic clock;
   logic reset;

   cle_req_if req_chan ();
   cle_rsp_if rsp_chan ();

   console_line_editor_echo i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   line_echo_scoreboard echo_board;

   // idle rates in percent, changed per phase by the stimulus
   int unsigned send_idle_pct = 12;
   int unsigned recv_idle_pct = 75;
   // hold-off requests from the stimulus, served by the receiver
   int unsigned holds_requested = 0;
   int unsigned bytes_sent = 0;
   int unsigned quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // any printable byte, upper half included, never delete
   function automatic logic [7:0] random_printable();
      logic [7:0] ch;
      ch = 8'($urandom_range(32, 254));
      if (ch == CH_DEL) ch = 8'hFF;
      return ch;
   endfunction

   function automatic logic [7:0] random_erase();
      return ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL;
   endfunction

   // one letter of either masked command word
   function automatic logic [7:0] cmd_char(input int unsigned which, input int unsigned idx);
      return (which == 0) ? mask_char_a(SCAN_W'(idx)) : mask_char_b(SCAN_W'(idx));
   endfunction

   // offer one byte, with random gaps before it, and wait for the block to take it
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      echo_board.note_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_cmd_word(input int unsigned which);
      int unsigned k;
      for (k = 0; k < WORD_LEN; k++) send_byte(cmd_char(which, k));
   endtask

   task automatic send_printables(input int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) send_byte(random_printable());
   endtask

   // one random line: mostly command lines and plain text, some noise
   task automatic send_random_line();
      int unsigned pick;
      int unsigned n;
      int unsigned k;
      int unsigned which;
      int unsigned cmd_len;
      logic [7:0]  cmd [WORD_LEN];
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
         which = $urandom_range(0, 1);
         for (k = 0; k < WORD_LEN; k++) cmd[k] = cmd_char(which, k);
         // sometimes a near miss, one letter off or cut short
         if ($urandom_range(0, 3) == 0) cmd[$urandom_range(0, WORD_LEN - 1)] = random_printable();
         cmd_len = WORD_LEN;
         if ($urandom_range(0, 5) == 0) cmd_len = WORD_LEN - 1;
         for (k = 0; k < cmd_len; k++) send_byte(cmd[k]);
         send_byte(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
         n = $urandom_range(0, 8);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) send_byte(random_erase());
            else send_byte(random_printable());
         end
         // now and then the line stays open and the next one appends to it
         if ($urandom_range(0, 5) != 0) send_byte(CH_CR);
      end else if (pick <= 6) begin
         n = $urandom_range(1, 12);
         for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 7))
               0:       send_byte(CH_SPACE);
               1:       send_byte(random_erase());
               2:       send_byte(CH_TAB);
               default: send_byte(random_printable());
            endcase
         end
         send_byte(CH_CR);
      end else if (pick <= 8) begin
         // raw noise over the whole byte range
         n = $urandom_range(1, 4);
         for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)));
      end else begin
         // a run of erases, often more than the line holds
         n = $urandom_range(1, 5);
         for (k = 0; k < n; k++) send_byte(random_erase());
      end
   endtask

   task automatic send_random_lines(input int unsigned count);
      int unsigned mark;
      mark = bytes_sent;
      while (bytes_sent < mark + count) send_random_line();
   endtask

   // receiver: random ready, plus one long hold-off per request
   initial begin : result_sink
      int unsigned holds_served;
      int unsigned held;
      holds_served   = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != holds_requested) begin
            holds_served++;
            rsp_chan.ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // every word the block hands over is checked against the predicted line edits
   always @(posedge clock) begin
      echo_word_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.kind        = event_kind_type'(rsp_chan.event_kind);
         got.echo_byte   = rsp_chan.echo_byte;
         got.line_length = rsp_chan.line_length;
         got.last        = rsp_chan.last_of_run;
         echo_board.check_word(got, $realtime);
      end
   end

   // watchdog on cycles where neither channel moves a word
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      echo_board       = new();
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase one: sender mostly busy, receiver mostly stalled
      send_idle_pct = 12;
      recv_idle_pct = 75;

      // ignored control bytes and erase on an empty line give nothing
      send_byte(8'h00);
      send_byte(8'h1F);
      send_byte(CH_BS);
      send_byte(CH_DEL);
      // empty line
      send_byte(CH_CR);
      // edges of the printable range, tab stored as space, both erase codes
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(CH_TAB);
      send_byte(8'h7E);
      send_byte(CH_BS);
      send_byte(CH_DEL);
      send_byte(CH_CR);
      // masked command: argument echoed as stars
      send_cmd_word(0);
      send_text(" a");
      send_byte(CH_CR);
      // tab as the separator, then erasing it unmasks again
      send_cmd_word(1);
      send_byte(CH_TAB);
      send_byte("k");
      send_byte(CH_BS);
      send_byte(CH_BS);
      send_byte("z");
      send_byte(CH_CR);

      send_random_lines(12);

      // phase two: the other way round
      send_idle_pct = 75;
      recv_idle_pct = 12;
      send_random_lines(12);

      // phase three: no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;

      // receiver holds off while bytes keep coming, the block has to stall its input
      send_byte("h");
      holds_requested++;
      send_printables(12);
      send_byte(CH_CR);

      send_random_lines(12);

      @(negedge clock);
      req_chan.valid <= 1'b0;

      // drain, the watchdog guards against a hang here
      while (echo_board.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes, %0d words checked: %0d lines, %0d overflows,",
               bytes_sent, echo_board.words_checked, echo_board.lines_done,
               echo_board.overflows);
      $display("%0d masked echoes, %0d erases, one long receiver hold-off",
               echo_board.masked_echoes, echo_board.erases);
      if (echo_board.expected_words.size() != 0) begin
         $display("%0d expected words never arrived", echo_board.expected_words.size());
      end
      if (echo_board.error_count == 0 && echo_board.expected_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
rtl/cle_pkg.sv
rtl/cle_if.sv
rtl/cle_line_ram.sv
rtl/cle_seq.sv
rtl/cle_rsp_stage.sv
rtl/console_line_editor_echo.sv
rtl/cle_checker.sv
test/cle_tb_pkg.sv
test/console_line_editor_echo_tb.sv
